// ----- rtl/prwm_pkg.sv -----
`timescale 1ns / 1ps

package prwm_pkg;

	// Panel geometry. Each controller chip drives half of the panel columns.
	localparam int PANEL_COLS = 1200;
	localparam int PANEL_ROWS = 1600;
	localparam int HALF_COLS  = PANEL_COLS / 2;
	// Frame-store byte where the second chip's half of a row begins.
	localparam int CHIP_BYTE_BASE = HALF_COLS / 2;
	localparam int MAX_DIM    = (PANEL_COLS > PANEL_ROWS) ? PANEL_COLS : PANEL_ROWS;

	// A panel coordinate holds 0 .. MAX_DIM-1.
	localparam int CRD_W  = $clog2(MAX_DIM);
	// Holds twice the largest coordinate plus one, with room for a sum.
	localparam int WIDE_W = 14;
	// Clip arithmetic on 16-bit inputs: a sum of two 17-bit values.
	localparam int CLP_W  = 18;

	typedef logic [CRD_W-1:0]         crd_t;
	typedef logic [WIDE_W-1:0]        wide_t;
	typedef logic signed [15:0]       in16_t;
	typedef logic signed [16:0]       ext17_t;
	typedef logic signed [CLP_W-1:0]  clp_t;

	// Configuration port.
	localparam int ADDR_W = 3;
	localparam logic REG_ROTATION = 1'b0;

	// Rotation codes.
	localparam logic [1:0] ROT_0 = 2'd0;
	localparam logic [1:0] ROT_1 = 2'd1;
	localparam logic [1:0] ROT_2 = 2'd2;
	localparam logic [1:0] ROT_3 = 2'd3;
	localparam logic [1:0] ROT_RESET = ROT_1;

	// Alignment: columns to groups of four, rows to pairs.
	localparam int COL_ALIGN_MASK = 3;
	localparam int ROW_ALIGN_MASK = 1;

	// Null window for a chip that the rectangle does not touch.
	localparam logic [10:0] NULL_H_START = 11'd0;
	localparam logic [10:0] NULL_H_END   = 11'h007;
	localparam logic [9:0]  NULL_V_START = 10'd0;
	localparam logic [9:0]  NULL_V_END   = 10'h001;
	localparam logic [10:0] NULL_BPR     = 11'd2;
	localparam logic [11:0] NULL_ROW0    = 12'd0;
	localparam logic [11:0] NULL_ROW1    = 12'd3;

	typedef struct packed {
		logic        chip_select;
		logic        window_real;
		logic [10:0] win_h_start;
		logic [10:0] win_h_end;
		logic [9:0]  win_v_start;
		logic [9:0]  win_v_end;
		logic [10:0] bytes_per_row;
		logic [10:0] row_byte_offset;
		logic [11:0] first_row;
		logic [11:0] final_row;
		logic        last;
	} res_t;

endpackage

// ----- rtl/prwm_intf.sv -----
`timescale 1ns / 1ps

interface prwm_rect_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] rect_left;
	logic signed [15:0] rect_top;
	logic signed [15:0] rect_width;
	logic signed [15:0] rect_height;

	modport source (output valid, rect_left, rect_top, rect_width, rect_height, input ready);
	modport sink (input valid, rect_left, rect_top, rect_width, rect_height, output ready);
endinterface

interface prwm_win_if;
	logic        valid;
	logic        ready;
	logic        chip_select;
	logic        window_real;
	logic [10:0] win_h_start;
	logic [10:0] win_h_end;
	logic [9:0]  win_v_start;
	logic [9:0]  win_v_end;
	logic [10:0] bytes_per_row;
	logic [10:0] row_byte_offset;
	logic [11:0] first_row;
	logic [11:0] final_row;
	logic        last;

	modport source (output valid, chip_select, window_real, win_h_start, win_h_end,
		win_v_start, win_v_end, bytes_per_row, row_byte_offset, first_row, final_row,
		last, input ready);
	modport sink (input valid, chip_select, window_real, win_h_start, win_h_end,
		win_v_start, win_v_end, bytes_per_row, row_byte_offset, first_row, final_row,
		last, output ready);
endinterface

// ----- rtl/partial_refresh_window_mapper.sv -----
`timescale 1ns / 1ps

// Partial refresh window mapper. Each beat on the rect channel is an update
// rectangle in user coordinates; for every rectangle that is not empty after
// clipping, the win channel gives two beats, first for the chip that drives
// the first half of the panel columns, then for the second-half chip (last
// is set on that one). A chip the rectangle does not touch gets the fixed
// 4x4 null window. Empty rectangles give no beats at all. The datapath is
// four register stages (left/top clip, right/bottom clip, rotation and
// alignment, per-chip window values), and a rectangle is registered in each
// of them in turn before its first beat is presented. The output stage holds
// one rectangle and presents its two beats in turn; it loads the next one
// only when its second beat is taken, so it cannot accept a new rectangle
// while beats of the last are pending. Rectangles that turn out empty leave
// the pipe early and do not occupy the output stage. The rotation register
// sits at byte address 0 of the APB port and resets to 1; it must only be
// written while the block is idle.
module partial_refresh_window_mapper (
	input  logic                           clk,
	input  logic                           arst_n,
	prwm_rect_if.sink                      rect,
	prwm_win_if.source                     win,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [prwm_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	localparam prwm_pkg::crd_t COL_MAX  = prwm_pkg::crd_t'(prwm_pkg::PANEL_COLS - 1);
	localparam prwm_pkg::crd_t ROW_MAX  = prwm_pkg::crd_t'(prwm_pkg::PANEL_ROWS - 1);
	localparam prwm_pkg::crd_t HALF_C   = prwm_pkg::crd_t'(prwm_pkg::HALF_COLS);
	localparam prwm_pkg::crd_t COL_MASK = prwm_pkg::crd_t'(prwm_pkg::COL_ALIGN_MASK);
	localparam prwm_pkg::crd_t ROW_MASK = prwm_pkg::crd_t'(prwm_pkg::ROW_ALIGN_MASK);

	// Register values for one chip whose window is real.
	function automatic prwm_pkg::res_t chip_window(logic chip, prwm_pkg::crd_t lcs,
			prwm_pkg::crd_t lce, prwm_pkg::crd_t rs, prwm_pkg::crd_t re,
			prwm_pkg::wide_t off_base);
		prwm_pkg::res_t r;
		prwm_pkg::wide_t wcs;
		prwm_pkg::wide_t wce;
		prwm_pkg::wide_t wrs;
		prwm_pkg::wide_t wre;
		prwm_pkg::wide_t t;
		wcs = prwm_pkg::wide_t'(lcs);
		wce = prwm_pkg::wide_t'(lce);
		wrs = prwm_pkg::wide_t'(rs);
		wre = prwm_pkg::wide_t'(re);
		r.chip_select = chip;
		r.window_real = 1'b1;
		t = wcs << 1;
		r.win_h_start = t[10:0];
		t = (wce << 1) | prwm_pkg::wide_t'(1);
		r.win_h_end = t[10:0];
		t = wrs >> 1;
		r.win_v_start = t[9:0];
		t = ((wre + prwm_pkg::wide_t'(1)) >> 1) - prwm_pkg::wide_t'(1);
		r.win_v_end = t[9:0];
		t = (wce - wcs + prwm_pkg::wide_t'(1)) >> 1;
		r.bytes_per_row = t[10:0];
		t = off_base + (wcs >> 1);
		r.row_byte_offset = t[10:0];
		r.first_row = wrs[11:0];
		r.final_row = wre[11:0];
		r.last = chip;
		return r;
	endfunction

	function automatic prwm_pkg::res_t null_window(logic chip, prwm_pkg::wide_t off_base);
		prwm_pkg::res_t r;
		r.chip_select = chip;
		r.window_real = 1'b0;
		r.win_h_start = prwm_pkg::NULL_H_START;
		r.win_h_end = prwm_pkg::NULL_H_END;
		r.win_v_start = prwm_pkg::NULL_V_START;
		r.win_v_end = prwm_pkg::NULL_V_END;
		r.bytes_per_row = prwm_pkg::NULL_BPR;
		r.row_byte_offset = off_base[10:0];
		r.first_row = prwm_pkg::NULL_ROW0;
		r.final_row = prwm_pkg::NULL_ROW1;
		r.last = chip;
		return r;
	endfunction

	// Configuration register.
	logic [1:0] rotation_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == prwm_pkg::REG_ROTATION);
	assign prdata = (paddr[2] == prwm_pkg::REG_ROTATION) ? {30'd0, rotation_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q <= prwm_pkg::ROT_RESET;
		end else if (cfg_wr) begin
			rotation_q <= pwdata[1:0];
		end
	end

	// Stage enables. A stage loads when it is empty or its contents move on;
	// the output stage frees up once its second beat is taken.
	logic v_s1, v_s2, v_s3, v_s4;
	logic phase_q;
	logic en1, en2, en3, en4;

	assign en4 = !v_s4 || (phase_q && win.ready);
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign rect.ready = en1;

	// Stage 1: clip against the left and top edges.
	prwm_pkg::in16_t  x_s1, y_s1;
	prwm_pkg::ext17_t w_s1, h_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= rect.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			x_s1 <= rect.rect_left[15] ? '0 : rect.rect_left;
			y_s1 <= rect.rect_top[15] ? '0 : rect.rect_top;
			w_s1 <= rect.rect_left[15]
				? prwm_pkg::ext17_t'(rect.rect_width) + prwm_pkg::ext17_t'(rect.rect_left)
				: prwm_pkg::ext17_t'(rect.rect_width);
			h_s1 <= rect.rect_top[15]
				? prwm_pkg::ext17_t'(rect.rect_height) + prwm_pkg::ext17_t'(rect.rect_top)
				: prwm_pkg::ext17_t'(rect.rect_height);
		end
	end

	// Stage 2: clip against the right and bottom edges of the user screen and
	// drop the rectangle if nothing is left. Coordinates become inclusive
	// start/end pairs.
	prwm_pkg::clp_t uw, uh, x_ext, y_ext, x_end, y_end, x_lim, y_lim;
	logic           keep2;
	prwm_pkg::crd_t xs_s2, xe_s2, ys_s2, ye_s2;

	always_comb begin
		if (rotation_q == prwm_pkg::ROT_0 || rotation_q == prwm_pkg::ROT_2) begin
			uw = prwm_pkg::clp_t'(prwm_pkg::PANEL_COLS);
			uh = prwm_pkg::clp_t'(prwm_pkg::PANEL_ROWS);
		end else begin
			uw = prwm_pkg::clp_t'(prwm_pkg::PANEL_ROWS);
			uh = prwm_pkg::clp_t'(prwm_pkg::PANEL_COLS);
		end
		x_ext = prwm_pkg::clp_t'(x_s1);
		y_ext = prwm_pkg::clp_t'(y_s1);
		x_end = x_ext + prwm_pkg::clp_t'(w_s1);
		y_end = y_ext + prwm_pkg::clp_t'(h_s1);
		x_lim = (x_end > uw) ? uw : x_end;
		y_lim = (y_end > uh) ? uh : y_end;
		keep2 = (w_s1 > 0) && (h_s1 > 0) && (x_ext < uw) && (y_ext < uh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1 && keep2;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			xs_s2 <= prwm_pkg::crd_t'(x_ext);
			ys_s2 <= prwm_pkg::crd_t'(y_ext);
			xe_s2 <= prwm_pkg::crd_t'(x_lim - prwm_pkg::clp_t'(1));
			ye_s2 <= prwm_pkg::crd_t'(y_lim - prwm_pkg::clp_t'(1));
		end
	end

	// Stage 3: map to panel columns and rows, then align outward and clamp.
	prwm_pkg::crd_t cs_m, ce_m, rs_m, re_m, ce_a, re_a;
	prwm_pkg::crd_t cs_s3, ce_s3, rs_s3, re_s3;

	always_comb begin
		case (rotation_q)
			prwm_pkg::ROT_0: begin
				cs_m = COL_MAX - xe_s2;
				ce_m = COL_MAX - xs_s2;
				rs_m = ROW_MAX - ye_s2;
				re_m = ROW_MAX - ys_s2;
			end
			prwm_pkg::ROT_2: begin
				cs_m = xs_s2;
				ce_m = xe_s2;
				rs_m = ys_s2;
				re_m = ye_s2;
			end
			prwm_pkg::ROT_3: begin
				cs_m = COL_MAX - ye_s2;
				ce_m = COL_MAX - ys_s2;
				rs_m = xs_s2;
				re_m = xe_s2;
			end
			default: begin
				cs_m = ys_s2;
				ce_m = ye_s2;
				rs_m = ROW_MAX - xe_s2;
				re_m = ROW_MAX - xs_s2;
			end
		endcase
		ce_a = ce_m | COL_MASK;
		re_a = re_m | ROW_MASK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			cs_s3 <= cs_m & ~COL_MASK;
			ce_s3 <= (ce_a > COL_MAX) ? COL_MAX : ce_a;
			rs_s3 <= rs_m & ~ROW_MASK;
			re_s3 <= (re_a > ROW_MAX) ? ROW_MAX : re_a;
		end
	end

	// Stage 4: window values for both chips; the output beats alternate
	// between them, first half first.
	prwm_pkg::res_t r0_n, r1_n, r0_s4, r1_s4, res;
	prwm_pkg::crd_t lce0, lcs1;

	always_comb begin
		lce0 = (ce_s3 < HALF_C) ? ce_s3 : HALF_C - prwm_pkg::crd_t'(1);
		lcs1 = (cs_s3 >= HALF_C) ? cs_s3 - HALF_C : '0;
		if (cs_s3 < HALF_C) begin
			r0_n = chip_window(1'b0, cs_s3, lce0, rs_s3, re_s3, '0);
		end else begin
			r0_n = null_window(1'b0, '0);
		end
		if (ce_s3 >= HALF_C) begin
			r1_n = chip_window(1'b1, lcs1, ce_s3 - HALF_C, rs_s3, re_s3,
				prwm_pkg::wide_t'(prwm_pkg::CHIP_BYTE_BASE));
		end else begin
			r1_n = null_window(1'b1, prwm_pkg::wide_t'(prwm_pkg::CHIP_BYTE_BASE));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (en4) begin
				v_s4 <= v_s3;
			end
			if (win.valid && win.ready) begin
				phase_q <= !phase_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			r0_s4 <= r0_n;
			r1_s4 <= r1_n;
		end
	end

	assign res = phase_q ? r1_s4 : r0_s4;

	assign win.valid           = v_s4;
	assign win.chip_select     = res.chip_select;
	assign win.window_real     = res.window_real;
	assign win.win_h_start     = res.win_h_start;
	assign win.win_h_end       = res.win_h_end;
	assign win.win_v_start     = res.win_v_start;
	assign win.win_v_end       = res.win_v_end;
	assign win.bytes_per_row   = res.bytes_per_row;
	assign win.row_byte_offset = res.row_byte_offset;
	assign win.first_row       = res.first_row;
	assign win.final_row       = res.final_row;
	assign win.last            = res.last;

endmodule
